// ===== hdl/lpu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the lens point undistorter.
`timescale 1ns / 1ps
package lpu_pkg;

  localparam int ITERATIONS = 20;
  localparam int DIV_BITS   = 32;
  localparam int FOCAL_W    = 20;
  localparam int PIX_W      = 20;
  localparam int OUT_W      = 22;
  localparam int CFG_W      = 40;

  localparam logic [FOCAL_W-1:0] FOCAL_RESET = 20'd131072;

  typedef enum logic [2:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_PRINCIPAL = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } cfg_reg_e;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic [31:0] xn;
    logic [31:0] yn;
    logic        clip;
  } ctx_t;

  typedef struct packed {
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
    logic [31:0] p1;
    logic [31:0] p2;
  } coef_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] v;
  } sat_t;

  // one divider lane between bit steps
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [31:0] den;
    logic        ovf;
    logic        neg;
    logic        dz;
    logic        npos;
    logic        nneg;
  } lane_t;

  function automatic sat_t sat32(input logic signed [39:0] v);
    sat_t r;
    if (v > 40'sd2147483647) begin
      r = '{clip: 1'b1, v: 32'h7fff_ffff};
    end else if (v < -40'sd2147483648) begin
      r = '{clip: 1'b1, v: 32'h8000_0000};
    end else begin
      r = '{clip: 1'b0, v: v[31:0]};
    end
    return r;
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [39:0] rshift(input logic signed [63:0] p, input int s);
    logic signed [64:0] t;
    t = $signed({p[63], p} + (65'd1 << (s - 1)));
    t = t >>> s;
    return t[39:0];
  endfunction

  function automatic logic signed [39:0] ext40(input logic [31:0] a);
    return $signed({{8{a[31]}}, a});
  endfunction

  // context with extra saturation flags folded in
  function automatic ctx_t clip_or(input ctx_t c, input logic f);
    ctx_t r;
    r      = c;
    r.clip = c.clip | f;
    return r;
  endfunction

endpackage

// ===== hdl/lpu_div.sv =====
// Two-lane pipelined restoring divider: round((num << 30) / den), saturated to 32 bits.
`timescale 1ns / 1ps
module lpu_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [1:0][31:0]    num_i,
  input  logic [1:0][31:0]    den_i,
  input  lpu_pkg::ctx_t       ctx_i,
  output logic                valid_o,
  output logic [1:0][31:0]    quo_o,
  output lpu_pkg::ctx_t       ctx_o
);

  localparam int NST = lpu_pkg::DIV_BITS + 2;

  lpu_pkg::lane_t ln_q [NST][2];
  lpu_pkg::lane_t ln_d [NST][2];
  lpu_pkg::ctx_t  cx_q [NST];
  logic [NST-1:0] vld_q;

  logic [1:0][31:0] quo_d;
  logic [1:0]       clp_d;
  logic [1:0][31:0] quo_q;
  lpu_pkg::ctx_t    ctx_q;
  logic             out_vld_q;

  always_comb begin
    logic [31:0] mag;
    logic [31:0] dmag;
    logic [61:0] nsum;
    logic [32:0] t;
    logic        ge;
    logic [32:0] q33;
    for (int l = 0; l < 2; l++) begin
      // entry: magnitudes and rounding offset
      mag  = num_i[l][31] ? 32'(-num_i[l]) : num_i[l];
      dmag = (den_i[l] == 32'd0) ? 32'd1 : (den_i[l][31] ? 32'(-den_i[l]) : den_i[l]);
      nsum = {mag, 30'd0} + 62'(dmag >> 1);
      ln_d[0][l].rem  = {2'b00, nsum[61:32]};
      ln_d[0][l].low  = nsum[31:0];
      ln_d[0][l].quo  = '0;
      ln_d[0][l].den  = dmag;
      ln_d[0][l].ovf  = 1'b0;
      ln_d[0][l].neg  = num_i[l][31] ^ den_i[l][31];
      ln_d[0][l].dz   = (den_i[l] == 32'd0);
      ln_d[0][l].npos = !num_i[l][31] && (num_i[l] != 32'd0);
      ln_d[0][l].nneg = num_i[l][31];
      // quotient of 2^32 or more
      ln_d[1][l]      = ln_q[0][l];
      ln_d[1][l].ovf  = (ln_q[0][l].rem >= ln_q[0][l].den);
      for (int j = 2; j < NST; j++) begin
        t  = {ln_q[j-1][l].rem, ln_q[j-1][l].low[31]};
        ge = (t >= {1'b0, ln_q[j-1][l].den});
        ln_d[j][l]     = ln_q[j-1][l];
        ln_d[j][l].rem = ge ? 32'(t - {1'b0, ln_q[j-1][l].den}) : t[31:0];
        ln_d[j][l].low = {ln_q[j-1][l].low[30:0], 1'b0};
        ln_d[j][l].quo = {ln_q[j-1][l].quo[30:0], ge};
      end
      // sign and saturation
      q33 = ln_q[NST-1][l].ovf ? 33'h1_0000_0000 : {1'b0, ln_q[NST-1][l].quo};
      if (ln_q[NST-1][l].dz) begin
        clp_d[l] = 1'b1;
        quo_d[l] = ln_q[NST-1][l].npos ? 32'h7fff_ffff :
                   (ln_q[NST-1][l].nneg ? 32'h8000_0000 : 32'd0);
      end else if (!ln_q[NST-1][l].neg) begin
        clp_d[l] = (q33 > 33'h0_7fff_ffff);
        quo_d[l] = clp_d[l] ? 32'h7fff_ffff : q33[31:0];
      end else begin
        clp_d[l] = (q33 > 33'h0_8000_0000);
        quo_d[l] = clp_d[l] ? 32'h8000_0000 : 32'(~q33[31:0] + 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[NST-2:0], valid_i};
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0] <= ctx_i;
    for (int j = 1; j < NST; j++) begin
      cx_q[j] <= cx_q[j-1];
    end
    for (int j = 0; j < NST; j++) begin
      ln_q[j] <= ln_d[j];
    end
    quo_q <= quo_d;
    ctx_q <= lpu_pkg::clip_or(cx_q[NST-1], |clp_d);
  end

  assign valid_o = out_vld_q;
  assign quo_o   = quo_q;
  assign ctx_o   = ctx_q;

endmodule

// ===== hdl/lpu_norm.sv =====
// Normalization front end: subtract the principal point and divide by the focal length.
`timescale 1ns / 1ps
module lpu_norm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [lpu_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [lpu_pkg::PIX_W-1:0]  pixel_y_i,
  input  logic [lpu_pkg::PIX_W-1:0]  cx_i,
  input  logic [lpu_pkg::PIX_W-1:0]  cy_i,
  input  logic [lpu_pkg::FOCAL_W-1:0] fx_i,
  input  logic [lpu_pkg::FOCAL_W-1:0] fy_i,
  output logic                       valid_o,
  output lpu_pkg::ctx_t              ctx_o
);

  logic             vld_q;
  logic [1:0][31:0] num_q;
  logic [1:0][31:0] den_q;
  logic             dvld;
  logic [1:0][31:0] quo;
  lpu_pkg::ctx_t    dctx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= 32'($signed({12'd0, pixel_x_i}) - $signed({12'd0, cx_i}));
    num_q[1] <= 32'($signed({12'd0, pixel_y_i}) - $signed({12'd0, cy_i}));
    den_q[0] <= {12'd0, fx_i};
    den_q[1] <= {12'd0, fy_i};
  end

  lpu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .ctx_i   ('0),
    .valid_o (dvld),
    .quo_o   (quo),
    .ctx_o   (dctx)
  );

  assign valid_o = dvld;
  assign ctx_o   = '{xn: quo[0], yn: quo[1], clip: dctx.clip};

endmodule

// ===== hdl/lpu_iter.sv =====
// One undistortion iteration: polynomial terms over nine stages, then the two divides.
`timescale 1ns / 1ps
module lpu_iter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [31:0]    x_i,
  input  logic [31:0]    y_i,
  input  lpu_pkg::ctx_t  ctx_i,
  input  lpu_pkg::coef_t coef_i,
  output logic           valid_o,
  output logic [31:0]    x_o,
  output logic [31:0]    y_o,
  output lpu_pkg::ctx_t  ctx_o
);

  logic [8:0] vld_q;

  lpu_pkg::ctx_t ctx_a_q, ctx_b_q, ctx_c_q, ctx_d_q, ctx_e_q, ctx_f_q, ctx_g_q, ctx_h_q,
                 ctx_i_q;
  logic signed [63:0] px2_a_q, py2_a_q, pxy_a_q;
  logic [31:0]        x2_b_q, y2_b_q, xy_b_q;
  logic [31:0]        r2_c_q, x2_c_q, y2_c_q, xy_c_q;
  logic signed [63:0] pr4_d_q, pk1_d_q;
  logic [31:0]        tx_d_q, ty_d_q, r2_d_q, xy_d_q;
  logic [31:0]        r4_e_q, r2_e_q;
  logic signed [39:0] k1t_e_q;
  logic signed [63:0] pp1xy_e_q, pp2tx_e_q, pp1ty_e_q, pp2xy_e_q;
  logic signed [63:0] pr6_f_q, pk2_f_q;
  logic [31:0]        dx_f_q, dy_f_q;
  logic signed [39:0] k1t_f_q;
  logic [31:0]        r6_g_q, dx_g_q, dy_g_q;
  logic signed [39:0] k1t_g_q, k2t_g_q;
  logic signed [63:0] pk3_h_q;
  logic [31:0]        nx_h_q, ny_h_q;
  logic signed [39:0] k1t_h_q, k2t_h_q;
  logic [31:0]        kr_i_q, nx_i_q, ny_i_q;

  lpu_pkg::sat_t x2_s, y2_s, xy_s, r2_s, tx_s, ty_s, r4_s, dx_s, dy_s, r6_s, nx_s, ny_s, kr_s;

  logic [1:0][31:0] dnum, dden, quo;

  always_comb begin
    x2_s = lpu_pkg::sat32(lpu_pkg::rshift(px2_a_q, 30));
    y2_s = lpu_pkg::sat32(lpu_pkg::rshift(py2_a_q, 30));
    xy_s = lpu_pkg::sat32(lpu_pkg::rshift(pxy_a_q, 30));
    r2_s = lpu_pkg::sat32(lpu_pkg::ext40(x2_b_q) + lpu_pkg::ext40(y2_b_q));
    tx_s = lpu_pkg::sat32(lpu_pkg::ext40(r2_c_q) + (lpu_pkg::ext40(x2_c_q) <<< 1));
    ty_s = lpu_pkg::sat32(lpu_pkg::ext40(r2_c_q) + (lpu_pkg::ext40(y2_c_q) <<< 1));
    r4_s = lpu_pkg::sat32(lpu_pkg::rshift(pr4_d_q, 30));
    dx_s = lpu_pkg::sat32(lpu_pkg::rshift(pp1xy_e_q, 27) + lpu_pkg::rshift(pp2tx_e_q, 28));
    dy_s = lpu_pkg::sat32(lpu_pkg::rshift(pp1ty_e_q, 28) + lpu_pkg::rshift(pp2xy_e_q, 27));
    r6_s = lpu_pkg::sat32(lpu_pkg::rshift(pr6_f_q, 30));
    nx_s = lpu_pkg::sat32(lpu_pkg::ext40(ctx_g_q.xn) - lpu_pkg::ext40(dx_g_q));
    ny_s = lpu_pkg::sat32(lpu_pkg::ext40(ctx_g_q.yn) - lpu_pkg::ext40(dy_g_q));
    kr_s = lpu_pkg::sat32(40'sh00_4000_0000 + k1t_h_q + k2t_h_q
                          + lpu_pkg::rshift(pk3_h_q, 28));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[7:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // A: squares and cross term
    ctx_a_q <= ctx_i;
    px2_a_q <= $signed(x_i) * $signed(x_i);
    py2_a_q <= $signed(y_i) * $signed(y_i);
    pxy_a_q <= $signed(x_i) * $signed(y_i);
    // B
    ctx_b_q <= lpu_pkg::clip_or(ctx_a_q, x2_s.clip | y2_s.clip | xy_s.clip);
    x2_b_q <= x2_s.v;
    y2_b_q <= y2_s.v;
    xy_b_q <= xy_s.v;
    // C
    ctx_c_q <= lpu_pkg::clip_or(ctx_b_q, r2_s.clip);
    r2_c_q <= r2_s.v;
    x2_c_q <= x2_b_q;
    y2_c_q <= y2_b_q;
    xy_c_q <= xy_b_q;
    // D
    ctx_d_q <= lpu_pkg::clip_or(ctx_c_q, tx_s.clip | ty_s.clip);
    pr4_d_q <= $signed(r2_c_q) * $signed(r2_c_q);
    pk1_d_q <= $signed(coef_i.k1) * $signed(r2_c_q);
    tx_d_q  <= tx_s.v;
    ty_d_q  <= ty_s.v;
    r2_d_q  <= r2_c_q;
    xy_d_q  <= xy_c_q;
    // E
    ctx_e_q <= lpu_pkg::clip_or(ctx_d_q, r4_s.clip);
    r4_e_q    <= r4_s.v;
    r2_e_q    <= r2_d_q;
    k1t_e_q   <= lpu_pkg::rshift(pk1_d_q, 28);
    pp1xy_e_q <= $signed(coef_i.p1) * $signed(xy_d_q);
    pp2tx_e_q <= $signed(coef_i.p2) * $signed(tx_d_q);
    pp1ty_e_q <= $signed(coef_i.p1) * $signed(ty_d_q);
    pp2xy_e_q <= $signed(coef_i.p2) * $signed(xy_d_q);
    // F
    ctx_f_q <= lpu_pkg::clip_or(ctx_e_q, dx_s.clip | dy_s.clip);
    pr6_f_q <= $signed(r4_e_q) * $signed(r2_e_q);
    pk2_f_q <= $signed(coef_i.k2) * $signed(r4_e_q);
    dx_f_q  <= dx_s.v;
    dy_f_q  <= dy_s.v;
    k1t_f_q <= k1t_e_q;
    // G
    ctx_g_q <= lpu_pkg::clip_or(ctx_f_q, r6_s.clip);
    r6_g_q  <= r6_s.v;
    k2t_g_q <= lpu_pkg::rshift(pk2_f_q, 28);
    k1t_g_q <= k1t_f_q;
    dx_g_q  <= dx_f_q;
    dy_g_q  <= dy_f_q;
    // H
    ctx_h_q <= lpu_pkg::clip_or(ctx_g_q, nx_s.clip | ny_s.clip);
    pk3_h_q <= $signed(coef_i.k3) * $signed(r6_g_q);
    nx_h_q  <= nx_s.v;
    ny_h_q  <= ny_s.v;
    k1t_h_q <= k1t_g_q;
    k2t_h_q <= k2t_g_q;
    // I: radial factor
    ctx_i_q <= lpu_pkg::clip_or(ctx_h_q, kr_s.clip);
    kr_i_q <= kr_s.v;
    nx_i_q <= nx_h_q;
    ny_i_q <= ny_h_q;
  end

  assign dnum[0] = nx_i_q;
  assign dnum[1] = ny_i_q;
  assign dden[0] = kr_i_q;
  assign dden[1] = kr_i_q;

  lpu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[8]),
    .num_i   (dnum),
    .den_i   (dden),
    .ctx_i   (ctx_i_q),
    .valid_o (valid_o),
    .quo_o   (quo),
    .ctx_o   (ctx_o)
  );

  assign x_o = quo[0];
  assign y_o = quo[1];

endmodule

// ===== hdl/lpu_out.sv =====
// Back to pixels: f * x + c, rounded, clamped to signed Q13.8.
`timescale 1ns / 1ps
module lpu_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [31:0]                 x_i,
  input  logic [31:0]                 y_i,
  input  logic                        clip_i,
  input  logic [lpu_pkg::FOCAL_W-1:0] fx_i,
  input  logic [lpu_pkg::FOCAL_W-1:0] fy_i,
  input  logic [lpu_pkg::PIX_W-1:0]   cx_i,
  input  logic [lpu_pkg::PIX_W-1:0]   cy_i,
  output logic                        valid_o,
  output logic [lpu_pkg::OUT_W-1:0]   ux_o,
  output logic [lpu_pkg::OUT_W-1:0]   uy_o,
  output logic                        clip_o
);

  localparam logic signed [39:0] OMAX = 40'sd2097151;
  localparam logic signed [39:0] OMIN = -40'sd2097152;

  logic [1:0]         vld_q;
  logic signed [63:0] prx_q, pry_q;
  logic               clp_q;
  logic signed [39:0] sx, sy;
  logic [lpu_pkg::OUT_W-1:0] ux_q, uy_q;
  logic               clip_q;
  logic               cx_clp, cy_clp;

  always_comb begin
    sx = lpu_pkg::rshift(prx_q, 30) + $signed({20'd0, cx_i});
    sy = lpu_pkg::rshift(pry_q, 30) + $signed({20'd0, cy_i});
    cx_clp = (sx > OMAX) || (sx < OMIN);
    cy_clp = (sy > OMAX) || (sy < OMIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prx_q  <= $signed({1'b0, fx_i}) * $signed(x_i);
    pry_q  <= $signed({1'b0, fy_i}) * $signed(y_i);
    clp_q  <= clip_i;
    ux_q   <= (sx > OMAX) ? OMAX[lpu_pkg::OUT_W-1:0] :
              (sx < OMIN) ? OMIN[lpu_pkg::OUT_W-1:0] : sx[lpu_pkg::OUT_W-1:0];
    uy_q   <= (sy > OMAX) ? OMAX[lpu_pkg::OUT_W-1:0] :
              (sy < OMIN) ? OMIN[lpu_pkg::OUT_W-1:0] : sy[lpu_pkg::OUT_W-1:0];
    clip_q <= clp_q | cx_clp | cy_clp;
  end

  assign valid_o = vld_q[1];
  assign ux_o    = ux_q;
  assign uy_o    = uy_q;
  assign clip_o  = clip_q;

endmodule

// ===== hdl/lens_point_undistort.sv =====
// Path from start to done: normalize, then 20 iterations, then the output stage.
// Throughput: one word per cycle; busy_o stays low, each stage is a pipeline register.
// Each divide is a 35-stage bit-per-stage restoring pipeline; it sets the depth.
// done_o pulses for one cycle with the result; the receiver cannot stall.
// Reset: valid bits clear, focal lengths go to 512.0, all other configuration registers to zero.
`timescale 1ns / 1ps
module lens_point_undistort (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lpu_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [lpu_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [lpu_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic [lpu_pkg::OUT_W-1:0]   undist_x_o,
  output logic [lpu_pkg::OUT_W-1:0]   undist_y_o,
  output logic                        clipped_o
);

  logic [lpu_pkg::FOCAL_W-1:0] focal_x_q, focal_y_q;
  logic [39:0]                 pp_q;
  lpu_pkg::coef_t              coef_q;
  logic [lpu_pkg::FOCAL_W-1:0] fx, fy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= lpu_pkg::FOCAL_RESET;
      focal_y_q <= lpu_pkg::FOCAL_RESET;
      pp_q      <= '0;
      coef_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (lpu_pkg::cfg_reg_e'(cfg_idx_i))
        lpu_pkg::REG_FOCAL_X:   focal_x_q <= cfg_wdata_i[19:0];
        lpu_pkg::REG_FOCAL_Y:   focal_y_q <= cfg_wdata_i[19:0];
        lpu_pkg::REG_PRINCIPAL: pp_q      <= cfg_wdata_i;
        lpu_pkg::REG_K1:        coef_q.k1 <= cfg_wdata_i[31:0];
        lpu_pkg::REG_K2:        coef_q.k2 <= cfg_wdata_i[31:0];
        lpu_pkg::REG_K3:        coef_q.k3 <= cfg_wdata_i[31:0];
        lpu_pkg::REG_P1:        coef_q.p1 <= cfg_wdata_i[31:0];
        lpu_pkg::REG_P2:        coef_q.p2 <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // zero focal length acts as one LSB
  assign fx = (focal_x_q == '0) ? 20'd1 : focal_x_q;
  assign fy = (focal_y_q == '0) ? 20'd1 : focal_y_q;

  assign busy_o = 1'b0;

  logic          vld   [lpu_pkg::ITERATIONS+1];
  logic [31:0]   xs    [lpu_pkg::ITERATIONS+1];
  logic [31:0]   ys    [lpu_pkg::ITERATIONS+1];
  lpu_pkg::ctx_t ctxs  [lpu_pkg::ITERATIONS+1];

  lpu_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cx_i      (pp_q[19:0]),
    .cy_i      (pp_q[39:20]),
    .fx_i      (fx),
    .fy_i      (fy),
    .valid_o   (vld[0]),
    .ctx_o     (ctxs[0])
  );

  assign xs[0] = ctxs[0].xn;
  assign ys[0] = ctxs[0].yn;

  for (genvar g = 0; g < lpu_pkg::ITERATIONS; g++) begin : g_iter
    lpu_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .x_i     (xs[g]),
      .y_i     (ys[g]),
      .ctx_i   (ctxs[g]),
      .coef_i  (coef_q),
      .valid_o (vld[g+1]),
      .x_o     (xs[g+1]),
      .y_o     (ys[g+1]),
      .ctx_o   (ctxs[g+1])
    );
  end

  lpu_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[lpu_pkg::ITERATIONS]),
    .x_i     (xs[lpu_pkg::ITERATIONS]),
    .y_i     (ys[lpu_pkg::ITERATIONS]),
    .clip_i  (ctxs[lpu_pkg::ITERATIONS].clip),
    .fx_i    (fx),
    .fy_i    (fy),
    .cx_i    (pp_q[19:0]),
    .cy_i    (pp_q[39:20]),
    .valid_o (done_o),
    .ux_o    (undist_x_o),
    .uy_o    (undist_y_o),
    .clip_o  (clipped_o)
  );

endmodule
